// ----- hw/rtl/gauss_seidel_laplace_grid_solver_unit_defines.svh -----
`ifndef GAUSS_SEIDEL_LAPLACE_GRID_SOLVER_UNIT_DEFINES_SVH
`define GAUSS_SEIDEL_LAPLACE_GRID_SOLVER_UNIT_DEFINES_SVH

// same-cycle implication
`define GSLG_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gslg check failed");

// next-cycle implication
`define GSLG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gslg check failed");

`endif

// ----- hw/rtl/gslg_pkg.sv -----
`default_nettype none

package gslg_pkg;

    localparam int IDX_W       = 6;
    localparam int MAX_N       = 63;
    localparam int FRAC_BITS   = 16;
    localparam int VAL_W       = FRAC_BITS + 1;
    localparam int SWP_W       = 16;
    localparam int ST_W        = 2;
    localparam int ADDR_W      = 2 * IDX_W;
    localparam int DEPTH       = 1 << ADDR_W;
    localparam int DEN_W       = 2 * IDX_W;
    localparam int NUM_W       = DEN_W + FRAC_BITS;
    localparam int DCNT_W      = $clog2(NUM_W);
    localparam int SUM_W       = VAL_W + 2;
    localparam int ONE_FX      = 1 << FRAC_BITS;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 17;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 40;
    localparam int OUT_PAD_W   = OUT_TDATA_W - VAL_W - SWP_W;

    localparam logic [IDX_W-1:0]      RESET_N   = IDX_W'(10);
    localparam logic [VAL_W-1:0]      RESET_TOL = VAL_W'(66);
    localparam logic [SWP_W-1:0]      RESET_MAX = SWP_W'(65535);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INTERVALS,
        CFG_TOLERANCE,
        CFG_MAX_SWEEPS
    } t_cfg_idx;

    typedef enum logic [ST_W-1:0] {
        ST_OK,
        ST_LIMIT,
        ST_RANGE,
        ST_NOSOLVE
    } t_status;

    typedef enum logic {
        REQ_SOLVE,
        REQ_READ
    } t_req;

    typedef enum logic [2:0] {
        TAP_WEST,
        TAP_EAST,
        TAP_NORTH,
        TAP_SOUTH,
        TAP_CENTER
    } t_tap;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INIT,
        S_DIV,
        S_DIV_WR,
        S_SW_RD,
        S_SW_CTR,
        S_SW_WR,
        S_SW_END,
        S_RD_MEM,
        S_RD_CAP,
        S_DONE
    } t_state;

    function automatic logic [IDX_W-1:0] clamp_n(input logic [IDX_W-1:0] n);
        logic [IDX_W-1:0] r;
        r = n;
        if (n < IDX_W'(2)) begin
            r = IDX_W'(2);
        end else if (n > IDX_W'(MAX_N)) begin
            r = IDX_W'(MAX_N);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/gslg_ram.sv -----
`default_nettype none

module gslg_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- hw/rtl/gauss_seidel_laplace_grid_solver_unit.sv -----
// read: the value is read from the grid ram when in range, else returned as zero
// solve: grid setup over (N+1)^2 points (one 28-step divider per edge point),
//   then sweeps of the (N-1)^2 interior points, one at a time, on the single ram read port
// one transaction at a time: no new request is taken until the result is handed off
// reset: control clears, registers return to N=10, tolerance 66, limit 65535,
//   no solve recorded; grid ram contents are undefined until the first solve
`default_nettype none

module gauss_seidel_laplace_grid_solver_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [gslg_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [gslg_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [gslg_pkg::IN_TDATA_W-1:0]    s_axis_tdata,  // row [5:0], col [11:6], zero [15:12]
    input  logic                               s_axis_tuser,  // req_type [0]
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [gslg_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,  // value [16:0], sweeps_done [32:17], zero [39:33]
    output logic [gslg_pkg::ST_W-1:0]          m_axis_tuser   // status [1:0]
);

    import gslg_pkg::*;

    t_state             r_state, n_state;
    logic [IDX_W-1:0]   r_i, n_i;
    logic [IDX_W-1:0]   r_j, n_j;
    logic [IDX_W-1:0]   r_n, n_n;
    logic [DEN_W-1:0]   r_den, n_den;
    logic [NUM_W-1:0]   r_num, n_num;
    logic [DEN_W-1:0]   r_rem, n_rem;
    logic [DCNT_W-1:0]  r_dcnt, n_dcnt;
    t_tap               r_tap, n_tap;
    logic [SUM_W-1:0]   r_sum, n_sum;
    logic [VAL_W-1:0]   r_nv, n_nv;
    logic [VAL_W-1:0]   r_ctr, n_ctr;
    logic [VAL_W-1:0]   r_dmax, n_dmax;
    logic [SWP_W-1:0]   r_cnt, n_cnt;
    logic               r_solved, n_solved;
    logic               r_conv, n_conv;
    logic [SWP_W-1:0]   r_sweeps, n_sweeps;
    logic [IDX_W-1:0]   r_sn, n_sn;
    logic [VAL_W-1:0]   r_res_val, n_res_val;
    t_status            r_res_st, n_res_st;
    logic [IDX_W-1:0]   r_cfg_n, n_cfg_n;
    logic [VAL_W-1:0]   r_cfg_tol, n_cfg_tol;
    logic [SWP_W-1:0]   r_cfg_max, n_cfg_max;
    logic               r_ovalid, n_ovalid;
    logic [VAL_W-1:0]   r_o_val, n_o_val;
    logic [SWP_W-1:0]   r_o_sw, n_o_sw;
    t_status            r_o_st, n_o_st;

    logic               w_in_acc;
    logic [IDX_W-1:0]   w_row, w_col;
    logic               w_oslot;
    logic [IDX_W-1:0]   w_n_eff;
    logic [DEN_W-1:0]   w_nn;
    logic               w_edge;
    logic [IDX_W-1:0]   w_k;
    logic [DEN_W-1:0]   w_kk;
    logic [DEN_W:0]     w_trial;
    logic               w_init_last;
    logic [IDX_W-1:0]   w_nm1;
    logic               w_sweep_last;
    logic [VAL_W-1:0]   w_diff;
    logic [SWP_W-1:0]   w_cnt1;
    logic               w_conv;
    logic               w_limit;
    logic               w_out_range;
    t_status            w_solve_st;

    logic               w_we;
    logic [ADDR_W-1:0]  w_waddr;
    logic [VAL_W-1:0]   w_wdata;
    logic               w_re;
    logic [ADDR_W-1:0]  w_raddr;
    logic [VAL_W-1:0]   w_rdata;

    gslg_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH)
    ) u_grid (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_in_acc     = s_axis_tvalid && s_axis_tready;
    assign w_row        = s_axis_tdata[IDX_W-1:0];
    assign w_col        = s_axis_tdata[2*IDX_W-1:IDX_W];
    assign w_oslot      = !r_ovalid || m_axis_tready;
    assign w_n_eff      = clamp_n(r_cfg_n);
    assign w_nn         = DEN_W'(w_n_eff) * DEN_W'(w_n_eff);
    assign w_edge       = (r_i == r_n) || (r_j == r_n);
    assign w_k          = (r_j == r_n) ? r_i : r_j;
    assign w_kk         = DEN_W'(w_k) * DEN_W'(w_k);
    assign w_trial      = {r_rem, r_num[NUM_W-1]};
    assign w_init_last  = (r_i == r_n) && (r_j == r_n);
    assign w_nm1        = r_n - IDX_W'(1);
    assign w_sweep_last = (r_i == w_nm1) && (r_j == w_nm1);
    assign w_diff       = (r_nv >= r_ctr) ? (r_nv - r_ctr) : (r_ctr - r_nv);
    assign w_cnt1       = r_cnt + SWP_W'(1);
    assign w_conv       = (r_dmax <= r_cfg_tol);
    assign w_limit      = (w_cnt1 >= r_cfg_max);
    assign w_out_range  = (w_row > r_sn) || (w_col > r_sn);
    assign w_solve_st   = r_conv ? ST_OK : ST_LIMIT;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    if (t_req'(s_axis_tuser) == REQ_SOLVE) begin
                        n_state = S_INIT;
                    end else if (!r_solved || w_out_range) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_RD_MEM;
                    end
                end
            end
            S_INIT: begin
                if (w_edge) begin
                    n_state = S_DIV;
                end else if (w_init_last) begin
                    n_state = S_SW_RD;
                end
            end
            S_DIV: begin
                if (r_dcnt == DCNT_W'(NUM_W - 1)) begin
                    n_state = S_DIV_WR;
                end
            end
            S_DIV_WR: begin
                n_state = w_init_last ? S_SW_RD : S_INIT;
            end
            S_SW_RD: begin
                if (r_tap == TAP_CENTER) begin
                    n_state = S_SW_CTR;
                end
            end
            S_SW_CTR: n_state = S_SW_WR;
            S_SW_WR: begin
                n_state = w_sweep_last ? S_SW_END : S_SW_RD;
            end
            S_SW_END: begin
                n_state = (w_conv || w_limit) ? S_DONE : S_SW_RD;
            end
            S_RD_MEM: n_state = S_RD_CAP;
            S_RD_CAP: n_state = S_DONE;
            S_DONE: begin
                if (w_oslot) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs: handshake and ram port
    always_comb begin
        s_axis_tready = 1'b0;
        w_we          = 1'b0;
        w_waddr       = {r_i, r_j};
        w_wdata       = '0;
        w_re          = 1'b0;
        w_raddr       = {r_i, r_j};
        case (r_state)
            S_IDLE: s_axis_tready = 1'b1;
            S_INIT: w_we = !w_edge;
            S_DIV_WR: begin
                w_we    = 1'b1;
                w_wdata = r_num[VAL_W-1:0];
            end
            S_SW_RD: begin
                w_re = 1'b1;
                case (r_tap)
                    TAP_WEST:   w_raddr = {r_i, r_j - IDX_W'(1)};
                    TAP_EAST:   w_raddr = {r_i, r_j + IDX_W'(1)};
                    TAP_NORTH:  w_raddr = {r_i - IDX_W'(1), r_j};
                    TAP_SOUTH:  w_raddr = {r_i + IDX_W'(1), r_j};
                    default:    w_raddr = {r_i, r_j};
                endcase
            end
            S_SW_WR: begin
                w_we    = 1'b1;
                w_wdata = r_nv;
            end
            S_RD_MEM: w_re = 1'b1;
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    // datapath
    always_comb begin
        n_i       = r_i;
        n_j       = r_j;
        n_n       = r_n;
        n_den     = r_den;
        n_num     = r_num;
        n_rem     = r_rem;
        n_dcnt    = r_dcnt;
        n_tap     = r_tap;
        n_sum     = r_sum;
        n_nv      = r_nv;
        n_ctr     = r_ctr;
        n_dmax    = r_dmax;
        n_cnt     = r_cnt;
        n_solved  = r_solved;
        n_conv    = r_conv;
        n_sweeps  = r_sweeps;
        n_sn      = r_sn;
        n_res_val = r_res_val;
        n_res_st  = r_res_st;
        n_cfg_n   = r_cfg_n;
        n_cfg_tol = r_cfg_tol;
        n_cfg_max = r_cfg_max;
        n_ovalid  = m_axis_tready ? 1'b0 : r_ovalid;
        n_o_val   = r_o_val;
        n_o_sw    = r_o_sw;
        n_o_st    = r_o_st;

        if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_INTERVALS:  n_cfg_n   = i_cfg_data[IDX_W-1:0];
                CFG_TOLERANCE:  n_cfg_tol = i_cfg_data[VAL_W-1:0];
                CFG_MAX_SWEEPS: n_cfg_max = i_cfg_data[SWP_W-1:0];
                default:        n_cfg_n   = r_cfg_n;
            endcase
        end

        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_res_val = '0;
                    if (t_req'(s_axis_tuser) == REQ_SOLVE) begin
                        n_n   = w_n_eff;
                        n_den = w_nn;
                        n_i   = '0;
                        n_j   = '0;
                    end else begin
                        n_i = w_row;
                        n_j = w_col;
                        if (!r_solved) begin
                            n_res_st = ST_NOSOLVE;
                        end else if (w_out_range) begin
                            n_res_st = ST_RANGE;
                        end else begin
                            n_res_st = w_solve_st;
                        end
                    end
                end
            end
            S_INIT, S_DIV_WR: begin
                if ((r_state == S_INIT) && w_edge) begin
                    n_rem  = '0;
                    n_dcnt = '0;
                    n_num  = {w_kk, {FRAC_BITS{1'b0}}} + NUM_W'(r_den >> 1);
                end else if (r_j == r_n) begin
                    n_j = '0;
                    if (r_i == r_n) begin
                        n_i    = IDX_W'(1);
                        n_j    = IDX_W'(1);
                        n_dmax = '0;
                        n_cnt  = '0;
                        n_tap  = TAP_WEST;
                    end else begin
                        n_i = r_i + IDX_W'(1);
                    end
                end else begin
                    n_j = r_j + IDX_W'(1);
                end
            end
            S_DIV: begin
                n_dcnt = r_dcnt + DCNT_W'(1);
                if (w_trial >= {1'b0, r_den}) begin
                    n_rem = DEN_W'(w_trial - {1'b0, r_den});
                    n_num = {r_num[NUM_W-2:0], 1'b1};
                end else begin
                    n_rem = w_trial[DEN_W-1:0];
                    n_num = {r_num[NUM_W-2:0], 1'b0};
                end
            end
            S_SW_RD: begin
                case (r_tap)
                    TAP_WEST:   n_sum = '0;
                    TAP_EAST:   n_sum = SUM_W'(w_rdata);
                    default:    n_sum = r_sum + SUM_W'(w_rdata);
                endcase
                n_tap = (r_tap == TAP_CENTER) ? TAP_WEST : t_tap'(r_tap + 3'd1);
            end
            S_SW_CTR: begin
                n_nv  = VAL_W'((r_sum + SUM_W'(2)) >> 2);
                n_ctr = w_rdata;
            end
            S_SW_WR: begin
                if (w_diff > r_dmax) begin
                    n_dmax = w_diff;
                end
                n_tap = TAP_WEST;
                if (r_j == w_nm1) begin
                    n_j = IDX_W'(1);
                    if (r_i != w_nm1) begin
                        n_i = r_i + IDX_W'(1);
                    end
                end else begin
                    n_j = r_j + IDX_W'(1);
                end
            end
            S_SW_END: begin
                n_cnt = w_cnt1;
                if (w_conv || w_limit) begin
                    n_solved  = 1'b1;
                    n_conv    = w_conv;
                    n_sweeps  = w_cnt1;
                    n_sn      = r_n;
                    n_res_val = '0;
                    n_res_st  = w_conv ? ST_OK : ST_LIMIT;
                end else begin
                    n_dmax = '0;
                    n_i    = IDX_W'(1);
                    n_j    = IDX_W'(1);
                end
            end
            S_RD_CAP: n_res_val = w_rdata;
            S_DONE: begin
                if (w_oslot) begin
                    n_ovalid = 1'b1;
                    n_o_val  = r_res_val;
                    n_o_sw   = r_sweeps;
                    n_o_st   = r_res_st;
                end
            end
            default: n_tap = r_tap;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ovalid  <= 1'b0;
            r_solved  <= 1'b0;
            r_conv    <= 1'b0;
            r_sweeps  <= '0;
            r_sn      <= '0;
            r_cfg_n   <= RESET_N;
            r_cfg_tol <= RESET_TOL;
            r_cfg_max <= RESET_MAX;
        end else begin
            r_state   <= n_state;
            r_ovalid  <= n_ovalid;
            r_solved  <= n_solved;
            r_conv    <= n_conv;
            r_sweeps  <= n_sweeps;
            r_sn      <= n_sn;
            r_cfg_n   <= n_cfg_n;
            r_cfg_tol <= n_cfg_tol;
            r_cfg_max <= n_cfg_max;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i       <= n_i;
        r_j       <= n_j;
        r_n       <= n_n;
        r_den     <= n_den;
        r_num     <= n_num;
        r_rem     <= n_rem;
        r_dcnt    <= n_dcnt;
        r_tap     <= n_tap;
        r_sum     <= n_sum;
        r_nv      <= n_nv;
        r_ctr     <= n_ctr;
        r_dmax    <= n_dmax;
        r_cnt     <= n_cnt;
        r_res_val <= n_res_val;
        r_res_st  <= n_res_st;
        r_o_val   <= n_o_val;
        r_o_sw    <= n_o_sw;
        r_o_st    <= n_o_st;
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, r_o_sw, r_o_val};
    assign m_axis_tuser  = r_o_st;

endmodule

`default_nettype wire

// ----- hw/rtl/gslg_checker.sv -----
`default_nettype none

`include "gauss_seidel_laplace_grid_solver_unit_defines.svh"

module gslg_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    input  logic                              s_axis_tready,
    input  logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    input  logic [gslg_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    input  logic [gslg_pkg::ST_W-1:0]         m_axis_tuser
);

    import gslg_pkg::*;

    logic w_s_acc;
    logic w_no_data;

    assign w_s_acc   = s_axis_tvalid && s_axis_tready;
    assign w_no_data = (m_axis_tuser == ST_RANGE) || (m_axis_tuser == ST_NOSOLVE);

    `GSLG_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, w_s_acc, !s_axis_tready)

    `GSLG_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

    `GSLG_ASSERT_SAME(a_zero_without_data, i_clk, i_rst_n, m_axis_tvalid && w_no_data, m_axis_tdata[VAL_W-1:0] == '0)

    `GSLG_ASSERT_SAME(a_no_sweeps_before_solve, i_clk, i_rst_n, m_axis_tvalid && (m_axis_tuser == ST_NOSOLVE), m_axis_tdata[VAL_W+SWP_W-1:VAL_W] == '0)

    `GSLG_ASSERT_SAME(a_value_in_range, i_clk, i_rst_n, m_axis_tvalid, m_axis_tdata[VAL_W-1:0] <= VAL_W'(ONE_FX))

endmodule

bind gauss_seidel_laplace_grid_solver_unit gslg_checker u_gslg_checker (.*);

`default_nettype wire

// ----- dv/gauss_seidel_laplace_grid_solver_unit_checker.sv -----
module gauss_seidel_laplace_grid_solver_unit_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [gslg_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [gslg_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_req_valid,
    input  logic                                i_req_ready,
    input  logic [gslg_pkg::IN_TDATA_W-1:0]     i_req_data,   // row [5:0], col [11:6], zero [15:12]
    input  logic                                i_req_user,   // req_type [0]
    input  logic                                i_rsp_valid,
    input  logic                                i_rsp_ready,
    input  logic [gslg_pkg::OUT_TDATA_W-1:0]    i_rsp_data,   // value [16:0], sweeps_done [32:17], zero [39:33]
    input  logic [gslg_pkg::ST_W-1:0]           i_rsp_user,   // status [1:0]
    output int                                  o_errors,
    output int                                  o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import gslg_pkg::*;

    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic [SWP_W-1:0] sweeps;
        t_status          status;
    } t_point_reply;

    t_point_reply     reply_q [$];

    logic [IDX_W-1:0] n_reg;
    logic [VAL_W-1:0] tol_reg;
    logic [SWP_W-1:0] max_reg;

    logic [VAL_W-1:0] grid_mem [0:MAX_N][0:MAX_N];
    bit               have_solve;
    bit               converged;
    logic [SWP_W-1:0] sweeps_last;
    int unsigned      solve_n;

    function automatic logic [VAL_W-1:0] edge_level(int unsigned k, int unsigned n);
        longint unsigned den;
        longint unsigned num;
        den = longint'(n) * longint'(n);
        num = longint'(k) * longint'(k) * longint'(ONE_FX);
        return VAL_W'((num + den / 2) / den);
    endfunction

    function automatic void run_solve();
        int unsigned      n;
        int unsigned      cnt;
        int unsigned      sum;
        int unsigned      nv;
        int unsigned      cur;
        int unsigned      d;
        int unsigned      dmax;
        logic [VAL_W-1:0] v;
        n = 32'(n_reg);
        if (n < 2) begin
            n = 2;
        end
        if (n > MAX_N) begin
            n = MAX_N;
        end
        for (int i = 0; i <= n; i++) begin
            for (int j = 0; j <= n; j++) begin
                v = '0;
                if (i == n) begin
                    v = edge_level(j, n);
                end
                if (j == n) begin
                    v = edge_level(i, n);
                end
                grid_mem[i][j] = v;
            end
        end
        cnt = 0;
        forever begin
            dmax = 0;
            for (int i = 1; i < n; i++) begin
                for (int j = 1; j < n; j++) begin
                    sum = int'(grid_mem[i][j-1]) + int'(grid_mem[i][j+1])
                        + int'(grid_mem[i-1][j]) + int'(grid_mem[i+1][j]);
                    nv  = (sum + 2) >> 2;
                    cur = 32'(grid_mem[i][j]);
                    d   = (nv > cur) ? nv - cur : cur - nv;
                    if (d > dmax) begin
                        dmax = d;
                    end
                    grid_mem[i][j] = VAL_W'(nv);
                end
            end
            cnt++;
            if (dmax <= 32'(tol_reg)) begin
                converged = 1'b1;
                break;
            end
            if (cnt >= 32'(max_reg)) begin
                converged = 1'b0;
                break;
            end
        end
        sweeps_last = SWP_W'(cnt);
        have_solve  = 1'b1;
        solve_n     = n;
    endfunction

    function automatic t_point_reply predict_reply(t_req rq, int unsigned r, int unsigned c);
        t_point_reply p;
        p.value  = '0;
        p.sweeps = '0;
        p.status = ST_OK;
        if (rq == REQ_SOLVE) begin
            run_solve();
            p.status = converged ? ST_OK : ST_LIMIT;
        end else if (!have_solve) begin
            p.status = ST_NOSOLVE;
        end else if (r > solve_n || c > solve_n) begin
            p.status = ST_RANGE;
        end else begin
            p.value  = grid_mem[r][c];
            p.status = converged ? ST_OK : ST_LIMIT;
        end
        if (have_solve) begin
            p.sweeps = sweeps_last;
        end
        return p;
    endfunction

    function automatic void note_fail(string msg);
        o_errors++;
        if (o_errors <= 10) begin
            $display("%t: %s", $realtime, msg);
        end
    endfunction

    always @(posedge i_clk) begin
        t_point_reply want;
        t_point_reply got;
        logic [OUT_TDATA_W-VAL_W-SWP_W-1:0] pad;
        if (!i_rst_n) begin
            n_reg       = RESET_N;
            tol_reg     = RESET_TOL;
            max_reg     = RESET_MAX;
            have_solve  = 1'b0;
            converged   = 1'b0;
            sweeps_last = '0;
            solve_n     = 0;
            reply_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_INTERVALS:  n_reg   = i_cfg_data[IDX_W-1:0];
                    CFG_TOLERANCE:  tol_reg = i_cfg_data[VAL_W-1:0];
                    CFG_MAX_SWEEPS: max_reg = i_cfg_data[SWP_W-1:0];
                    default: ;
                endcase
            end
            if (i_req_valid && i_req_ready) begin
                reply_q.push_back(predict_reply(t_req'(i_req_user),
                                                32'(i_req_data[IDX_W-1:0]),
                                                32'(i_req_data[2*IDX_W-1:IDX_W])));
            end
            if (i_rsp_valid && i_rsp_ready) begin
                got.value  = i_rsp_data[VAL_W-1:0];
                got.sweeps = i_rsp_data[VAL_W +: SWP_W];
                got.status = t_status'(i_rsp_user);
                pad        = i_rsp_data[OUT_TDATA_W-1:VAL_W+SWP_W];
                if (reply_q.size() == 0) begin
                    note_fail($sformatf("unexpected transaction: value=%0d sweeps=%0d status=%0d",
                                        got.value, got.sweeps, got.status));
                end else begin
                    want = reply_q.pop_front();
                    if (want != got || pad != '0) begin
                        note_fail($sformatf({"mismatch: expected value=%0d sweeps=%0d status=%0d",
                                             " got value=%0d sweeps=%0d status=%0d pad=%0h"},
                                            want.value, want.sweeps, want.status,
                                            got.value, got.sweeps, got.status, pad));
                    end
                end
            end
        end
        o_pending = reply_q.size();
    end

endmodule

// ----- dv/gauss_seidel_laplace_grid_solver_unit_test.sv -----
module gauss_seidel_laplace_grid_solver_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import gslg_pkg::*;

    localparam int                    HOLD_CYCLES  = 300;
    localparam int                    STALL_LIMIT  = 400000;
    localparam int                    RANDOM_ITEMS = 76;
    localparam logic [CFG_IDX_W-1:0]  CFG_SPARE    = CFG_IDX_W'(3);
    localparam logic [IDX_W-1:0]      IDX_TOP      = IDX_W'(MAX_N);

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    i_cfg_we;
    logic [CFG_IDX_W-1:0]    i_cfg_idx;
    logic [CFG_DATA_W-1:0]   i_cfg_data;
    logic                    s_axis_tvalid;
    logic                    s_axis_tready;
    logic [IN_TDATA_W-1:0]   s_axis_tdata;   // row [5:0], col [11:6], zero [15:12]
    logic                    s_axis_tuser;   // req_type [0]
    logic                    m_axis_tvalid;
    logic                    m_axis_tready;
    logic [OUT_TDATA_W-1:0]  m_axis_tdata;   // value [16:0], sweeps_done [32:17], zero [39:33]
    logic [ST_W-1:0]         m_axis_tuser;   // status [1:0]

    int errors;
    int pending;
    int n_sent;
    int eff_n;
    int stall_cnt;
    bit no_idle;
    bit hold_start;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    gauss_seidel_laplace_grid_solver_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    gauss_seidel_laplace_grid_solver_unit_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_req_valid (s_axis_tvalid),
        .i_req_ready (s_axis_tready),
        .i_req_data  (s_axis_tdata),
        .i_req_user  (s_axis_tuser),
        .i_rsp_valid (m_axis_tvalid),
        .i_rsp_ready (m_axis_tready),
        .i_rsp_data  (m_axis_tdata),
        .i_rsp_user  (m_axis_tuser),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    // result side: random backpressure, one long hold-off on request
    initial begin
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_start) begin
                hold_start = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                m_axis_tready <= no_idle || ($urandom_range(0, 99) >= 29);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (s_axis_tvalid && s_axis_tready)
                || (m_axis_tvalid && m_axis_tready)) begin
            stall_cnt <= 0;
        end else if (stall_cnt >= STALL_LIMIT) begin
            $display("** gauss_seidel_laplace_grid_solver_unit: FAILED **");
            $finish;
        end else begin
            stall_cnt <= stall_cnt + 1;
        end
    end

    task automatic send_req(t_req rq, logic [IDX_W-1:0] r, logic [IDX_W-1:0] c);
        if (!no_idle && $urandom_range(0, 99) < 29) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4) + (($urandom_range(0, 9) == 0) ? 20 : 0))
                @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= rq;
        s_axis_tdata  <= {{(IN_TDATA_W - 2*IDX_W){1'b0}}, c, r};
        do @(posedge i_clk); while (!s_axis_tready);
        n_sent++;
    endtask

    task automatic read_rand();
        logic [IDX_W-1:0] r;
        logic [IDX_W-1:0] c;
        if ($urandom_range(0, 4) != 0) begin
            r = IDX_W'($urandom_range(0, eff_n));
            c = IDX_W'($urandom_range(0, eff_n));
        end else begin
            r = IDX_W'($urandom_range(0, MAX_N));
            c = IDX_W'($urandom_range(0, MAX_N));
        end
        send_req(REQ_READ, r, c);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic set_cfg(logic [CFG_DATA_W-1:0] n_word, logic [CFG_DATA_W-1:0] tol_word,
                           logic [CFG_DATA_W-1:0] ms_word);
        wait_drained();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_INTERVALS;
        i_cfg_data <= n_word;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_TOLERANCE;
        i_cfg_data <= tol_word;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_MAX_SWEEPS;
        i_cfg_data <= ms_word;
        @(posedge i_clk);
        // unmapped index, must not disturb anything
        i_cfg_idx  <= CFG_SPARE;
        i_cfg_data <= CFG_DATA_W'($urandom);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        eff_n = int'(n_word[IDX_W-1:0]);
        if (eff_n < 2) begin
            eff_n = 2;
        end
    endtask

    initial begin
        int                    phase;
        int                    dir_count;
        int                    run_len;
        int unsigned           n_pick;
        int unsigned           tol_pick;
        int unsigned           ms_pick;
        logic [CFG_DATA_W-1:0] n_word;
        logic [CFG_DATA_W-1:0] ms_word;

        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= CFG_INTERVALS;
        i_cfg_data    <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= REQ_SOLVE;
        eff_n = 10;
        n_sent = 0;
        no_idle = 1'b0;
        hold_start = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // nothing solved yet
        send_req(REQ_READ, 0, 0);
        send_req(REQ_READ, IDX_TOP, IDX_TOP);

        // settings out of reset
        send_req(REQ_SOLVE, IDX_W'($urandom), IDX_W'($urandom));
        send_req(REQ_READ, 10, 10);
        send_req(REQ_READ, 5, 5);
        send_req(REQ_READ, 10, 0);
        send_req(REQ_READ, 0, 10);
        send_req(REQ_READ, 11, 3);

        // N of one clamps to two, zero sweep limit runs one sweep
        set_cfg(17'h1FFC1, 17'h00000, 17'h10000);
        send_req(REQ_SOLVE, IDX_TOP, IDX_TOP);
        send_req(REQ_READ, 1, 1);
        send_req(REQ_READ, 2, 2);
        send_req(REQ_READ, 3, 0);

        // N of zero, exact convergence, largest limit
        set_cfg(17'h00000, 17'h00000, 17'h0FFFF);
        send_req(REQ_SOLVE, 0, 0);
        send_req(REQ_READ, 1, 1);

        // largest grid, stopped by the limit
        set_cfg(17'h0003F, 17'h00000, 17'h00002);
        send_req(REQ_SOLVE, 0, IDX_TOP);
        send_req(REQ_READ, IDX_TOP, IDX_TOP);
        send_req(REQ_READ, IDX_TOP, 0);
        send_req(REQ_READ, 0, IDX_TOP);
        send_req(REQ_READ, 31, 32);

        // converged on the limit sweep
        set_cfg(17'h00005, 17'h1FFFF, 17'h00001);
        send_req(REQ_SOLVE, 0, 0);
        send_req(REQ_READ, 3, 2);
        set_cfg(17'h00005, 17'h10000, 17'h00001);
        send_req(REQ_SOLVE, 0, 0);
        send_req(REQ_READ, 5, 4);
        dir_count = n_sent;

        phase = 0;
        while (n_sent < dir_count + RANDOM_ITEMS) begin
            phase++;
            n_pick = $urandom_range(0, 7);
            case ($urandom_range(0, 2))
                0:       tol_pick = 0;
                1:       tol_pick = $urandom_range(0, 300);
                default: tol_pick = $urandom_range(0, 131071);
            endcase
            ms_pick = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 60);
            n_word  = {11'($urandom), 6'(n_pick)};
            ms_word = {1'($urandom), 16'(ms_pick)};
            set_cfg(n_word, CFG_DATA_W'(tol_pick), ms_word);
            no_idle = (phase == 3);
            send_req(REQ_SOLVE, IDX_W'($urandom), IDX_W'($urandom));
            run_len = $urandom_range(4, 12);
            for (int k = 0; k < run_len; k++) begin
                // result side stalls while requests keep coming
                if (phase == 2 && k == 1) begin
                    hold_start = 1'b1;
                end
                if ($urandom_range(0, 11) == 0) begin
                    send_req(REQ_SOLVE, IDX_W'($urandom), IDX_W'($urandom));
                end else begin
                    read_rand();
                end
            end
        end
        no_idle = 1'b0;

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (errors == 0) begin
            $display("** gauss_seidel_laplace_grid_solver_unit: PASSED **");
        end else begin
            $display("** gauss_seidel_laplace_grid_solver_unit: FAILED **");
        end
        $finish;
    end

endmodule
